// ----- hdl/sose_pkg.sv -----
package sose_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_TOP   = 2'd2,
        ACT_POPAT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        STEP_INC = 1'b0,
        STEP_DEC = 1'b1
    } step_op_t;

    localparam logic [31:0] MOST_NEG   = 32'h8000_0000;
    localparam logic [4:0]  THR_RESET  = 5'd10;

endpackage

// ----- hdl/set_of_stacks_engine_core.sv -----
// Set-of-stacks engine: one logical stack kept in NUM_SUBSTACKS substacks of
// SUBSTACK_DEPTH slots each.
// Input channel (in_valid/in_ready) carries one request word: action, data,
// index. Output channel (out_valid/out_ready) carries one result word per
// request: value, status, is_empty. cfg_we/cfg_data write the threshold
// (entries per substack before the next one opens); the user must do so only
// while idle, as the block itself does not enforce it.
// Timing: one request is worked at a time; in_ready is high only in idle.
// From acceptance a push runs S_CNT, S_TOT, S_FIN, with S_ADV and a second
// S_CNT before S_TOT when it opens a new substack; pop, pop-at and top run
// S_CNT, S_ENT, S_FIN, pop and top repeating S_CNT for each empty substack
// walked over; an empty result goes from S_CNT to S_FIN, an out-of-range
// pop-at from idle. Idle comes again before the next word is taken. The
// count memory read is registered and feeds the shared step unit (one
// increment or decrement and one compare per cycle). Reset: counters and the
// sequencer clear at once, then a clearing pass zeroes the substack count
// memory, one entry a cycle, with in_ready low. The entry memory is never
// cleared. Receiver stall: the finished result waits in the output register;
// the sequencer holds its result until that register is free.
module set_of_stacks_engine_core #(
    parameter int NUM_SUBSTACKS  = 128,
    parameter int SUBSTACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] data,
    input  logic [6:0]  index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic [1:0]  status,
    output logic        is_empty
);

    localparam int IW  = $clog2(NUM_SUBSTACKS);
    localparam int CW  = $clog2(SUBSTACK_DEPTH + 1);
    localparam int ENT = NUM_SUBSTACKS * SUBSTACK_DEPTH;
    localparam int EW  = $clog2(ENT);
    localparam int TW  = $clog2(ENT + 1);
    localparam logic [IW-1:0] LAST_SUB = IW'(NUM_SUBSTACKS - 1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_CNT,
        S_ADV,
        S_ENT,
        S_TOT,
        S_FIN
    } state_t;

    state_t                  state_reg, state_next;
    logic [IW-1:0]           cur_reg, cur_next;
    logic [TW-1:0]           total_reg, total_next;
    logic [4:0]              thr_reg;
    logic [IW-1:0]           clr_reg, clr_next;
    sose_pkg::action_t       act_reg, act_next;
    logic [31:0]             data_reg, data_next;
    logic [IW-1:0]           sub_reg, sub_next;
    logic                    adv_reg, adv_next;
    logic [31:0]             val_reg, val_next;
    sose_pkg::status_t       st_reg, st_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             out_value_reg, out_value_next;
    sose_pkg::status_t       out_status_reg, out_status_next;
    logic                    out_empty_reg, out_empty_next;

    // threshold after clamping to 1..SUBSTACK_DEPTH
    logic [31:0]             thr_wide;
    logic [TW-1:0]           thr_eff;

    logic [31:0]             idx_wide;
    logic                    idx_ok;
    logic [IW-1:0]           idx_addr;
    logic [IW-1:0]           wsub;

    // step unit
    logic [TW-1:0]           u_a, u_b, u_y;
    sose_pkg::step_op_t      u_op;
    logic                    u_ge;

    // memories
    logic                    cnt_we;
    logic [IW-1:0]           cnt_waddr, cnt_raddr;
    logic [CW-1:0]           cnt_wdata, cnt_rdata;
    logic                    ent_we;
    logic [EW-1:0]           ent_waddr, ent_raddr;
    logic [31:0]             ent_rdata;

    function automatic logic [EW-1:0] ent_addr(input logic [IW-1:0] s,
                                               input logic [CW-1:0] off);
        ent_addr = EW'(s) * EW'(SUBSTACK_DEPTH) + EW'(off);
    endfunction

    always_comb
    begin
        thr_wide = 32'(thr_reg);
        if (thr_wide == 32'd0)
        begin
            thr_wide = 32'd1;
        end
        if (thr_wide > 32'(SUBSTACK_DEPTH))
        begin
            thr_wide = 32'(SUBSTACK_DEPTH);
        end
        thr_eff = thr_wide[TW-1:0];
    end

    assign idx_wide = 32'(index);
    assign idx_ok   = (idx_wide < 32'(NUM_SUBSTACKS));
    assign idx_addr = idx_wide[IW-1:0];
    assign wsub     = (act_reg == sose_pkg::ACT_POPAT) ? sub_reg : cur_reg;

    sose_step_unit #(
        .WIDTH (TW)
    ) u_step (
        .a  (u_a),
        .b  (u_b),
        .op (u_op),
        .y  (u_y),
        .ge (u_ge)
    );

    sose_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_SUBSTACKS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    sose_ram #(
        .WIDTH (32),
        .DEPTH (ENT)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (data_reg),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // Route the step unit by state.
    always_comb
    begin
        u_a  = TW'(cnt_rdata);
        u_b  = thr_eff;
        u_op = sose_pkg::STEP_INC;
        case (state_reg)
            S_CNT:
            begin
                if (act_reg == sose_pkg::ACT_PUSH)
                begin
                    u_a  = TW'(cnt_rdata);
                    u_op = sose_pkg::STEP_INC;
                end
                else if (cnt_rdata == '0)
                begin
                    // step back one substack
                    u_a  = TW'(cur_reg);
                    u_op = sose_pkg::STEP_DEC;
                end
                else
                begin
                    u_a  = TW'(cnt_rdata);
                    u_op = sose_pkg::STEP_DEC;
                end
            end
            S_ADV:
            begin
                u_a  = TW'(cur_reg);
                u_b  = TW'(LAST_SUB);
                u_op = sose_pkg::STEP_INC;
            end
            S_ENT:
            begin
                u_a  = total_reg;
                u_op = sose_pkg::STEP_DEC;
            end
            S_TOT:
            begin
                u_a  = total_reg;
                u_op = sose_pkg::STEP_INC;
            end
            default:
            begin
                u_a  = TW'(cnt_rdata);
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        total_next      = total_reg;
        clr_next        = clr_reg;
        act_next        = act_reg;
        data_next       = data_reg;
        sub_next        = sub_reg;
        adv_next        = adv_reg;
        val_next        = val_reg;
        st_next         = st_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_empty_next  = out_empty_reg;

        cnt_we    = 1'b0;
        cnt_waddr = wsub;
        cnt_wdata = u_y[CW-1:0];
        cnt_raddr = wsub;
        ent_we    = 1'b0;
        ent_waddr = ent_addr(wsub, cnt_rdata);
        ent_raddr = ent_addr(wsub, u_y[CW-1:0]);

        in_ready = (state_reg == S_IDLE);

        // drop the result once the receiver takes it
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == LAST_SUB)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cnt_raddr = (action == sose_pkg::ACT_POPAT) ? idx_addr : cur_reg;
                if (in_valid)
                begin
                    act_next  = sose_pkg::action_t'(action);
                    data_next = data;
                    sub_next  = idx_addr;
                    adv_next  = 1'b0;
                    val_next  = '0;
                    st_next   = sose_pkg::ST_OK;
                    if ((action == sose_pkg::ACT_POPAT) && !idx_ok)
                    begin
                        val_next   = sose_pkg::MOST_NEG;
                        st_next    = sose_pkg::ST_EMPTY;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_CNT;
                    end
                end
            end
            S_CNT:
            begin
                if (act_reg == sose_pkg::ACT_PUSH)
                begin
                    if (u_ge)
                    begin
                        if (adv_reg)
                        begin
                            st_next    = sose_pkg::ST_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_ADV;
                        end
                    end
                    else
                    begin
                        ent_we     = 1'b1;
                        cnt_we     = 1'b1;
                        state_next = S_TOT;
                    end
                end
                else if (cnt_rdata == '0)
                begin
                    if ((act_reg == sose_pkg::ACT_POPAT) || (cur_reg == '0))
                    begin
                        val_next   = sose_pkg::MOST_NEG;
                        st_next    = sose_pkg::ST_EMPTY;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cur_next  = u_y[IW-1:0];
                        cnt_raddr = u_y[IW-1:0];
                    end
                end
                else
                begin
                    if (act_reg != sose_pkg::ACT_TOP)
                    begin
                        cnt_we = 1'b1;
                    end
                    state_next = S_ENT;
                end
            end
            S_ADV:
            begin
                if (u_ge)
                begin
                    st_next    = sose_pkg::ST_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    cur_next   = u_y[IW-1:0];
                    cnt_raddr  = u_y[IW-1:0];
                    adv_next   = 1'b1;
                    state_next = S_CNT;
                end
            end
            S_ENT:
            begin
                val_next = ent_rdata;
                if (act_reg != sose_pkg::ACT_TOP)
                begin
                    total_next = u_y;
                end
                state_next = S_FIN;
            end
            S_TOT:
            begin
                total_next = u_y;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = val_reg;
                    out_status_next = st_reg;
                    out_empty_next  = (total_reg == '0);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            cur_reg        <= '0;
            total_reg      <= '0;
            thr_reg        <= sose_pkg::THR_RESET;
            clr_reg        <= '0;
            act_reg        <= sose_pkg::ACT_PUSH;
            data_reg       <= '0;
            sub_reg        <= '0;
            adv_reg        <= 1'b0;
            val_reg        <= '0;
            st_reg         <= sose_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= sose_pkg::ST_OK;
            out_empty_reg  <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            total_reg      <= total_next;
            clr_reg        <= clr_next;
            act_reg        <= act_next;
            data_reg       <= data_next;
            sub_reg        <= sub_next;
            adv_reg        <= adv_next;
            val_reg        <= val_next;
            st_reg         <= st_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_empty_reg  <= out_empty_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign status    = out_status_reg;
    assign is_empty  = out_empty_reg;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("word accepted while a request is still in work");

    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == sose_pkg::ST_EMPTY)) |-> (value == sose_pkg::MOST_NEG))
        else $error("empty result without the most negative value");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == sose_pkg::ST_FULL)) |-> !is_empty)
        else $error("full push reported with no entries held");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(ENT))
        else $error("entry total beyond capacity");
`endif

endmodule

// ----- hdl/sose_ram.sv -----
module sose_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/sose_step_unit.sv -----
module sose_step_unit #(
    parameter int WIDTH = 12
) (
    input  logic               [WIDTH-1:0] a,
    input  logic               [WIDTH-1:0] b,
    input  sose_pkg::step_op_t             op,
    output logic               [WIDTH-1:0] y,
    output logic                           ge
);

    assign y  = (op == sose_pkg::STEP_DEC) ? (a - WIDTH'(1)) : (a + WIDTH'(1));
    assign ge = (a >= b);

endmodule

// ----- dv/set_of_stacks_engine_core_test.sv -----
`timescale 1ns / 1ps

module set_of_stacks_engine_core_test;

    localparam int NSUB  = 128;
    localparam int DEPTH = 16;

    // One expected result word, as the block should return it
    typedef struct {
        logic [31:0]       value;
        sose_pkg::status_t status;
        logic              is_empty;
    } result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  action    = '0;
    logic [31:0] data      = '0;
    logic [6:0]  index     = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] value;
    logic [1:0]  status;
    logic        is_empty;

    // Shadow copy of the stack: slot contents, per-substack fill, top substack,
    // total entry count and the threshold register
    logic [31:0] slot_mem [0:NSUB*DEPTH-1];
    int unsigned fill [0:NSUB-1];
    int unsigned top_sub = 0;
    int unsigned held = 0;
    logic [4:0]  thr_reg = sose_pkg::THR_RESET;

    result_t     pending_results [$];
    int          mismatch_count = 0;
    bit          calm = 1'b0;      // set for the last part: no idling on either side

    set_of_stacks_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .data      (data),
        .index     (index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status),
        .is_empty  (is_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Hard stop: far beyond the slowest legal run (every word walking all
    // substacks, with the longest gaps and stalls on both sides)
    initial
    begin
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Work out the result of one accepted request word and update the shadow
    // state the way the block must.
    function automatic result_t stack_step(sose_pkg::action_t act, logic [31:0] d,
                                           logic [6:0] ix);
        result_t     r;
        int unsigned lim;
        logic        room;
        r.value  = '0;
        r.status = sose_pkg::ST_OK;
        // Clamp the threshold: zero acts as one, anything above the depth as the depth
        lim = (thr_reg == 0) ? 1 : int'(thr_reg);
        if (lim > DEPTH)
            lim = DEPTH;
        case (act)
            sose_pkg::ACT_PUSH:
            begin
                room = 1'b1;
                // Open the next substack once the current one is at threshold;
                // at the last substack the push is dropped as full
                if (fill[top_sub] >= lim)
                begin
                    if (top_sub + 1 >= NSUB)
                        room = 1'b0;
                    else
                        top_sub++;
                end
                if (room && fill[top_sub] < lim)
                begin
                    slot_mem[top_sub*DEPTH + fill[top_sub]] = d;
                    fill[top_sub]++;
                    held++;
                end
                else
                    r.status = sose_pkg::ST_FULL;
            end
            sose_pkg::ACT_POP, sose_pkg::ACT_TOP:
            begin
                // Walk back over every empty substack; the move is kept
                while (top_sub > 0 && fill[top_sub] == 0)
                    top_sub--;
                if (fill[top_sub] == 0)
                begin
                    r.value  = sose_pkg::MOST_NEG;
                    r.status = sose_pkg::ST_EMPTY;
                end
                else if (act == sose_pkg::ACT_POP)
                begin
                    fill[top_sub]--;
                    held--;
                    r.value = slot_mem[top_sub*DEPTH + fill[top_sub]];
                end
                else
                    r.value = slot_mem[top_sub*DEPTH + fill[top_sub] - 1];
            end
            default:
            begin
                // Pop from a named substack; an empty one gives the empty result
                if (ix >= NSUB || fill[ix] == 0)
                begin
                    r.value  = sose_pkg::MOST_NEG;
                    r.status = sose_pkg::ST_EMPTY;
                end
                else
                begin
                    fill[ix]--;
                    held--;
                    r.value = slot_mem[int'(ix)*DEPTH + fill[ix]];
                end
            end
        endcase
        r.is_empty = (held == 0);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h, want %h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Send one request word: optionally idle first, then hold valid and the
    // payload until the block takes the word, and record what it must return.
    task automatic send_word(sose_pkg::action_t act, logic [31:0] d, logic [6:0] ix);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        data     <= d;
        index    <= ix;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(stack_step(act, d, ix));
    endtask

    // Pick a random request. Pop-at mostly names a substack at or below the
    // current top, where entries can actually be.
    task automatic send_random(int push_pct, int popat_pct);
        int                roll;
        sose_pkg::action_t act;
        logic [6:0]        ix;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            act = sose_pkg::ACT_PUSH;
        else if (roll < push_pct + popat_pct)
            act = sose_pkg::ACT_POPAT;
        else
            act = ($urandom_range(0, 1) != 0) ? sose_pkg::ACT_POP : sose_pkg::ACT_TOP;
        ix = 7'($urandom);
        if (act == sose_pkg::ACT_POPAT && $urandom_range(0, 9) < 7)
            ix = 7'($urandom_range(0, top_sub));
        send_word(act, $urandom, ix);
    endtask

    // Drop valid, drain every pending result, wait for idle, then write the
    // threshold register.
    task automatic write_threshold(logic [4:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        thr_reg = v;
        cfg_we <= 1'b0;
    endtask

    // Empty requests on a fresh stack, then the data extremes at the reset threshold
    task automatic test_empty_and_extremes();
        send_word(sose_pkg::ACT_POP,   32'h0, 7'd0);
        send_word(sose_pkg::ACT_TOP,   32'h0, 7'd0);
        send_word(sose_pkg::ACT_POPAT, 32'h0, 7'd0);
        send_word(sose_pkg::ACT_POPAT, 32'hFFFF_FFFF, 7'd127);
        send_word(sose_pkg::ACT_PUSH,  32'h7FFF_FFFF, 7'd127);
        send_word(sose_pkg::ACT_PUSH,  32'h8000_0000, 7'd0);
        send_word(sose_pkg::ACT_TOP,   32'h0, 7'd0);
        send_word(sose_pkg::ACT_POP,   32'h0, 7'd0);
        send_word(sose_pkg::ACT_POP,   32'h0, 7'd0);
        send_word(sose_pkg::ACT_POP,   32'h0, 7'd0);
    endtask

    // Threshold zero acts as one: each push after the first opens a substack.
    // Drain a middle one with pop-at, then let top walk back over two empty
    // substacks. Then a threshold above the depth, which clamps to the depth.
    task automatic test_clamp_and_walk();
        write_threshold(5'd0);
        send_word(sose_pkg::ACT_PUSH,  32'h0000_0000, 7'd0);
        send_word(sose_pkg::ACT_PUSH,  32'hFFFF_FFFF, 7'd0);
        send_word(sose_pkg::ACT_PUSH,  32'h5555_AAAA, 7'd0);
        send_word(sose_pkg::ACT_POPAT, 32'h0, 7'd1);
        send_word(sose_pkg::ACT_POPAT, 32'h0, 7'd1);
        send_word(sose_pkg::ACT_POP,   32'h0, 7'd0);
        send_word(sose_pkg::ACT_TOP,   32'h0, 7'd0);
        send_word(sose_pkg::ACT_POP,   32'h0, 7'd0);
        write_threshold(5'd31);
        send_word(sose_pkg::ACT_PUSH,  32'hAAAA_5555, 7'd0);
        send_word(sose_pkg::ACT_PUSH,  32'h0000_0001, 7'd0);
        send_word(sose_pkg::ACT_POPAT, 32'h0, 7'd0);
        send_word(sose_pkg::ACT_TOP,   32'h0, 7'd0);
    endtask

    // Balanced traffic at a random legal threshold
    task automatic test_mixed_random();
        write_threshold(5'($urandom_range(1, 16)));
        repeat (230) send_random(55, 15);
    endtask

    // One entry per substack and mostly pushes: climb to the last substack
    // until pushes get dropped as full
    task automatic test_fill_until_full();
        write_threshold(5'd1);
        repeat (260) send_random(85, 5);
    endtask

    // Heavy pop-at leaves holes below the top; pops and tops then walk back
    task automatic test_holes_and_walk();
        write_threshold(5'($urandom_range(2, 5)));
        repeat (200) send_random(40, 35);
    endtask

    // Thresholds at or above the depth clamp to a full substack
    task automatic test_wide_threshold();
        write_threshold(5'($urandom_range(16, 31)));
        repeat (150) send_random(50, 15);
    endtask

    // Back to the reset threshold, then full speed with no idling at all
    task automatic test_steady_flow();
        write_threshold(sose_pkg::THR_RESET);
        calm = 1'b1;
        repeat (110) send_random(50, 20);
    endtask

    // Hold the receiver off in random bursts; keep it ready when calm
    initial
    begin : rx_pacing
        int n;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Check each result word taken from the block against the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result word, value", value, 32'h0);
            else
            begin
                want = pending_results.pop_front();
                if (value !== want.value)
                    report_mismatch("value", value, want.value);
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(is_empty), 32'(want.is_empty));
            end
        end
    end

    initial
    begin
        for (int i = 0; i < NSUB; i++)
            fill[i] = 0;
        // Hold reset, then release it; the block then runs its clearing pass
        // with in_ready low, which the first send simply waits out
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_and_extremes();
        test_clamp_and_walk();
        test_mixed_random();
        test_fill_until_full();
        test_holes_and_walk();
        test_wide_threshold();
        test_steady_flow();

        // Drain what is still in flight, then let the block settle before the verdict
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/sose_pkg.sv
hdl/sose_ram.sv
hdl/sose_step_unit.sv
hdl/set_of_stacks_engine_core.sv
dv/set_of_stacks_engine_core_test.sv
